// ===== design/knn_pkg.sv =====
package knn_pkg;

  localparam int DIST_BITS = 34;
  localparam logic [DIST_BITS-1:0] DIST_EMPTY = {DIST_BITS{1'b1}};
  localparam logic [DIST_BITS-1:0] DIST_SAT = {{(DIST_BITS-1){1'b1}}, 1'b0};
  localparam int KREG_BITS = 5;
  localparam int RANK_BITS = 4;
  localparam int OUT_INDEX_BITS = 24;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_CAND = 1'b1;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_SIFT,
    HOP_SORT
  } heap_op_t;

  typedef struct packed {
    logic start;
    heap_op_t op;
  } heap_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } heap_sts_t;

endpackage

// ===== design/knn_dist.sv =====
module knn_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_BITS-1:0]  qx,
  input  logic signed [COORD_BITS-1:0]  qy,
  input  logic signed [COORD_BITS-1:0]  qz,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic signed [COORD_BITS-1:0]  pz,
  output logic                          done,
  output logic [knn_pkg::DIST_BITS-1:0] dist_sq
);

  localparam int DW = COORD_BITS + 1;
  localparam int AW = (DW > 17) ? DW : 18;

  logic [1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [knn_pkg::DIST_BITS:0] acc_r, acc_nxt;
  logic signed [DW-1:0] diff;
  logic [AW-1:0] mag;
  logic [knn_pkg::DIST_BITS-1:0] sq;
  logic [knn_pkg::DIST_BITS:0] sum;

  always_comb begin
    case (cnt_r)
      2'd0: diff = DW'(qx) - DW'(px);
      2'd1: diff = DW'(qy) - DW'(py);
      default: diff = DW'(qz) - DW'(pz);
    endcase
  end

  assign mag = diff[DW-1] ? AW'(-diff) : AW'(diff);

  always_comb begin
    if (mag >= AW'(1 << 17)) begin
      sq = knn_pkg::DIST_SAT;
    end else begin
      sq = knn_pkg::DIST_BITS'(mag[16:0] * mag[16:0]);
      if (sq > knn_pkg::DIST_SAT) sq = knn_pkg::DIST_SAT;
    end
  end

  assign sum = acc_r + {1'b0, sq};

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = '0;
    end else if (busy_r) begin
      acc_nxt = (sum > {1'b0, knn_pkg::DIST_SAT}) ? {1'b0, knn_pkg::DIST_SAT} : sum;
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign dist_sq = acc_r[knn_pkg::DIST_BITS-1:0];

endmodule

// ===== design/knn_heap.sv =====
module knn_heap #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  knn_pkg::heap_cmd_t            cmd,
  input  logic                          fill,
  input  logic [INDEX_BITS-1:0]         fill_index,
  input  logic                          root_wr,
  input  logic [knn_pkg::DIST_BITS-1:0] root_dist,
  input  logic [INDEX_BITS-1:0]         root_index,
  input  logic [$clog2(MAX_NEIGHBORS+1)-1:0] k,
  input  logic [$clog2(MAX_NEIGHBORS+1)-1:0] rd_sel,
  output logic [knn_pkg::DIST_BITS-1:0] rd_dist,
  output logic [INDEX_BITS-1:0]         rd_index,
  output knn_pkg::heap_sts_t            sts
);

  localparam int SW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int NW = $clog2(MAX_NEIGHBORS + 1);
  localparam int CW = NW + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SIFT,
    S_SORT
  } state_t;

  state_t state_r;
  logic [knn_pkg::DIST_BITS-1:0] hd_r [MAX_NEIGHBORS];
  logic [INDEX_BITS-1:0] hi_r [MAX_NEIGHBORS];
  logic [CW-1:0] node_r;
  logic [NW-1:0] n_r;
  logic sorting_r;
  logic done_r;

  logic [CW-1:0] lc, rc, c;
  logic swap_en;
  logic [SW-1:0] na, ca;

  always_comb begin
    lc = (node_r << 1) + CW'(1);
    rc = lc + CW'(1);
    c = lc;
    swap_en = 1'b0;
    na = node_r[SW-1:0];
    ca = lc[SW-1:0];
    if (lc < CW'(n_r)) begin
      if (rc < CW'(n_r) && hd_r[rc[SW-1:0]] > hd_r[lc[SW-1:0]]) c = rc;
      ca = c[SW-1:0];
      swap_en = hd_r[na] < hd_r[ca];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r <= 1'b0;
      sorting_r <= 1'b0;
      for (int i = 0; i < MAX_NEIGHBORS; i++) begin
        hd_r[i] <= knn_pkg::DIST_EMPTY;
        hi_r[i] <= '0;
      end
    end else begin
      done_r <= 1'b0;
      if (fill) begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
          hd_r[i] <= knn_pkg::DIST_EMPTY;
          hi_r[i] <= fill_index;
        end
      end else if (root_wr) begin
        hd_r[0] <= root_dist;
        hi_r[0] <= root_index;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.start && cmd.op == knn_pkg::HOP_SIFT) begin
            node_r <= '0;
            n_r <= k;
            sorting_r <= 1'b0;
            state_r <= S_SIFT;
          end else if (cmd.start && cmd.op == knn_pkg::HOP_SORT) begin
            n_r <= k;
            sorting_r <= 1'b1;
            state_r <= S_SORT;
          end
        end
        S_SORT: begin
          if (n_r > NW'(1)) begin
            hd_r[0] <= hd_r[SW'(n_r - NW'(1))];
            hi_r[0] <= hi_r[SW'(n_r - NW'(1))];
            hd_r[SW'(n_r - NW'(1))] <= hd_r[0];
            hi_r[SW'(n_r - NW'(1))] <= hi_r[0];
            n_r <= n_r - NW'(1);
            node_r <= '0;
            state_r <= S_SIFT;
          end else begin
            done_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_SIFT: begin
          if (swap_en) begin
            hd_r[na] <= hd_r[ca];
            hi_r[na] <= hi_r[ca];
            hd_r[ca] <= hd_r[na];
            hi_r[ca] <= hi_r[na];
            node_r <= c;
          end else if (sorting_r) begin
            state_r <= S_SORT;
          end else begin
            done_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rd_dist = hd_r[rd_sel[SW-1:0]];
  assign rd_index = hi_r[rd_sel[SW-1:0]];
  assign sts.busy = (state_r != S_IDLE);
  assign sts.done = done_r;

endmodule

// ===== design/knn_heap_query_top.sv =====
// k-nearest-neighbor query over a bounded max-heap. A beat with op 0 loads the
// query point and refills all heap slots with the empty distance (all ones) and
// the beat's index. op 1 beats are candidates: the shared distance unit sums
// the squared axis differences one axis at a time, x then y then z. A
// candidate that beats the heap root replaces it and is sifted down with one
// compare-swap per heap level swapped (up to log2(K) levels). On tlast the K
// slots are heap-sorted in place, then K result beats leave in ascending
// distance, rank 0 first, one per cycle while out_tready is high, tlast on
// the final one; input stays closed until that beat is taken. Candidates
// arriving with no open query are dropped.
module knn_heap_query_top #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [knn_pkg::KREG_BITS-1:0] cfg_wdata,
  input  logic cfg_we,
  input  logic in_tvalid,
  output logic in_tready,
  // x_coord, y_coord, z_coord, point_index (lowest bit up), zero padded
  input  logic [((3*COORD_BITS+INDEX_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // neighbor_index, distance_sq, rank (lowest bit up), zero padded
  output logic [((knn_pkg::OUT_INDEX_BITS+knn_pkg::DIST_BITS+knn_pkg::RANK_BITS+7)/8)*8-1:0]
    out_tdata,
  output logic out_tlast
);

  localparam int NW = $clog2(MAX_NEIGHBORS + 1);
  localparam int OW =
    ((knn_pkg::OUT_INDEX_BITS + knn_pkg::DIST_BITS + knn_pkg::RANK_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIST,
    S_SIFT,
    S_SORT,
    S_EMIT
  } state_t;

  state_t state_r;
  logic [knn_pkg::KREG_BITS-1:0] kreg_r;
  logic open_r;
  logic last_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r, px_r, py_r, pz_r;
  logic [INDEX_BITS-1:0] pidx_r;
  logic [NW-1:0] k_r, emit_r;
  logic ov_r;
  logic [OW-1:0] od_r;
  logic olast_r;

  logic [NW-1:0] k_eff;
  logic dist_start, dist_done;
  logic [knn_pkg::DIST_BITS-1:0] dist_sq;
  knn_pkg::heap_cmd_t cmd;
  knn_pkg::heap_sts_t sts;
  logic fill, root_wr;
  logic [knn_pkg::DIST_BITS-1:0] rd_dist;
  logic [INDEX_BITS-1:0] rd_index;
  logic acc;

  always_comb begin
    if (kreg_r == '0) k_eff = NW'(1);
    else if (32'(kreg_r) > MAX_NEIGHBORS) k_eff = NW'(MAX_NEIGHBORS);
    else k_eff = NW'(kreg_r);
  end

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign fill = acc && (in_tuser == knn_pkg::OP_QUERY);
  assign dist_start = acc && (in_tuser == knn_pkg::OP_CAND) && open_r;
  assign root_wr = (state_r == S_DIST) && dist_done && (dist_sq < rd_dist);

  always_comb begin
    cmd.start = 1'b0;
    cmd.op = knn_pkg::HOP_NONE;
    if (root_wr) begin
      cmd.start = 1'b1;
      cmd.op = knn_pkg::HOP_SIFT;
    end else if ((state_r == S_SORT) && !sts.busy && !sts.done) begin
      cmd.start = 1'b1;
      cmd.op = knn_pkg::HOP_SORT;
    end
  end

  knn_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk(clk), .rst_n(rst_n), .start(dist_start),
    .qx(qx_r), .qy(qy_r), .qz(qz_r), .px(px_r), .py(py_r), .pz(pz_r),
    .done(dist_done), .dist_sq(dist_sq)
  );

  knn_heap #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .INDEX_BITS(INDEX_BITS)) u_heap (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .fill(fill),
    .fill_index(in_tdata[3*COORD_BITS +: INDEX_BITS]),
    .root_wr(root_wr), .root_dist(dist_sq), .root_index(pidx_r),
    .k(k_r), .rd_sel((state_r == S_EMIT) ? emit_r : '0),
    .rd_dist(rd_dist), .rd_index(rd_index), .sts(sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kreg_r <= knn_pkg::KREG_BITS'(16);
      open_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) kreg_r <= cfg_wdata;
      if (ov_r && out_tready && (state_r != S_EMIT)) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            px_r <= in_tdata[0 +: COORD_BITS];
            py_r <= in_tdata[COORD_BITS +: COORD_BITS];
            pz_r <= in_tdata[2*COORD_BITS +: COORD_BITS];
            pidx_r <= in_tdata[3*COORD_BITS +: INDEX_BITS];
            last_r <= in_tlast;
            k_r <= k_eff;
            if (in_tuser == knn_pkg::OP_QUERY) begin
              qx_r <= in_tdata[0 +: COORD_BITS];
              qy_r <= in_tdata[COORD_BITS +: COORD_BITS];
              qz_r <= in_tdata[2*COORD_BITS +: COORD_BITS];
              open_r <= 1'b1;
              if (in_tlast) state_r <= S_SORT;
            end else if (open_r) begin
              state_r <= S_DIST;
            end
          end
        end
        S_DIST: begin
          if (dist_done) begin
            if (root_wr) state_r <= S_SIFT;
            else if (last_r) state_r <= S_SORT;
            else state_r <= S_IDLE;
          end
        end
        S_SIFT: begin
          if (sts.done) state_r <= last_r ? S_SORT : S_IDLE;
        end
        S_SORT: begin
          if (sts.done) begin
            emit_r <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            od_r <= OW'({emit_r[knn_pkg::RANK_BITS-1:0], rd_dist,
                         rd_index[knn_pkg::OUT_INDEX_BITS-1:0]});
            olast_r <= (emit_r + NW'(1) == k_r);
            emit_r <= emit_r + NW'(1);
            if (emit_r + NW'(1) == k_r) begin
              open_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tlast = olast_r;

endmodule

// ===== design/knn_checker.sv =====
module knn_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast,
  input logic [3:0] out_rank
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out beat dropped");

  a_rank_zero_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid |-> out_rank == 4'd0)
    else $error("rank not restarted");

  a_busy_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready) else $error("input open mid output");

endmodule

bind knn_heap_query_top knn_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tlast(out_tlast),
  .out_rank(out_tdata[61:58])
);
